FILE: sv/cmg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the S-curve level table of the edge map core.
package cmg_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int FRAC_BITS  = 16;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS = 12;
    localparam int ROW_BITS   = 16;
    localparam int PIX_BITS   = 8;
    localparam int GAIN_BITS  = 8;
    localparam int OUT_BITS   = 8;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam longint unsigned CUBE_DEN = 64'd16581375;  // 255^3

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);
    localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = ROW_BITS'(480);
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET = GAIN_BITS'(10);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_EDGE_GAIN    = 2'd2
    } t_cfg_index;

    typedef logic [FRAC_BITS-1:0] t_level;
    typedef t_level [0:255] t_level_lut;

    // Position and neighbour qualifiers of one result, decided at input time.
    typedef struct packed {
        logic [COL_BITS-1:0] column;
        logic [ROW_BITS-1:0] row;
        logic                last;
        logic                left_v;
        logic                right_v;
        logic                above_v;
        logic                below_v;
    } t_item_ctl;

    typedef struct packed {
        t_level              diff;
        logic [COL_BITS-1:0] column;
        logic [ROW_BITS-1:0] row;
        logic                last;
    } t_diff_item;

    // Cubic S-curve: 4x^3 below one half, 1 + 4(x-1)^3 above, rounded half up.
    function automatic t_level_lut build_level_lut();
        t_level_lut      lut;
        longint unsigned q;
        longint unsigned num;
        longint unsigned t;
        longint unsigned one;
        one = 64'd1 << FRAC_BITS;
        for (int p = 0; p < 256; p++) begin
            q   = (p <= 127) ? longint'(p) : longint'(255 - p);
            num = ((64'd4 * q * q * q) << FRAC_BITS) + CUBE_DEN / 2;
            t   = num / CUBE_DEN;
            if (p > 127) begin
                t = one - t;
                if (t >= one) begin
                    t = one - 1;
                end
            end
            lut[p] = t[FRAC_BITS-1:0];
        end
        return lut;
    endfunction

    localparam t_level_lut LEVEL_LUT = build_level_lut();

endpackage

FILE: sv/cmg_frame_ctrl.sv
`timescale 1ns / 1ps
// Column and row counters, frame geometry latch and final-row flush tracking.
module cmg_frame_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [cmg_pkg::WIDTH_BITS-1:0]    i_frame_width,
    input  logic [cmg_pkg::ROW_BITS-1:0]      i_frame_height,
    output logic                              o_emit,
    output logic [cmg_pkg::COL_BITS-1:0]      o_col,
    output cmg_pkg::t_item_ctl                o_ctl
);

    localparam logic [cmg_pkg::WIDTH_BITS-1:0] MAX_W = cmg_pkg::WIDTH_BITS'(cmg_pkg::MAX_WIDTH);
    localparam logic [cmg_pkg::WIDTH_BITS-1:0] ONE_W = cmg_pkg::WIDTH_BITS'(1);
    localparam logic [cmg_pkg::ROW_BITS-1:0]   ONE_H = cmg_pkg::ROW_BITS'(1);

    logic [cmg_pkg::COL_BITS-1:0]   r_col, n_col;
    logic [cmg_pkg::ROW_BITS-1:0]   r_row, n_row;
    logic [cmg_pkg::WIDTH_BITS-1:0] r_w, n_w;
    logic [cmg_pkg::ROW_BITS-1:0]   r_h, n_h;
    logic [cmg_pkg::WIDTH_BITS-1:0] r_pw, n_pw;
    logic [cmg_pkg::ROW_BITS-1:0]   r_ph, n_ph;
    logic                           r_pend, n_pend;

    logic                           first;
    logic [cmg_pkg::WIDTH_BITS-1:0] fw;
    logic [cmg_pkg::ROW_BITS-1:0]   fh;
    logic [cmg_pkg::WIDTH_BITS-1:0] cx_w, cx1, row_w;
    logic [cmg_pkg::ROW_BITS-1:0]   row_h, res_row;
    logic                           emit;

    always_comb begin
        first = (r_col == '0) && (r_row == '0);
        fw = i_frame_width;
        if (fw == '0) begin
            fw = ONE_W;
        end else if (fw > MAX_W) begin
            fw = MAX_W;
        end
        fh = (i_frame_height == '0) ? ONE_H : i_frame_height;
        n_w  = first ? fw : r_w;
        n_h  = first ? fh : r_h;
        cx_w = {1'b0, r_col};
        cx1  = cx_w + ONE_W;

        emit    = 1'b0;
        row_w   = ONE_W;
        row_h   = ONE_H;
        res_row = '0;
        if (r_row != '0) begin
            emit    = 1'b1;
            row_w   = n_w;
            row_h   = n_h;
            res_row = r_row - ONE_H;
        end else if (r_pend && (cx_w < r_pw)) begin
            // flush the final row of the previous frame
            emit    = 1'b1;
            row_w   = r_pw;
            row_h   = r_ph;
            res_row = r_ph - ONE_H;
        end

        n_pend = r_pend;
        if ((r_row == '0) && ((cx1 >= r_pw) || (cx_w == n_w - ONE_W))) begin
            n_pend = 1'b0;
        end
        n_pw  = r_pw;
        n_ph  = r_ph;
        n_col = r_col + cmg_pkg::COL_BITS'(1);
        n_row = r_row;
        if (cx_w == n_w - ONE_W) begin
            n_col = '0;
            if (r_row == n_h - ONE_H) begin
                n_row  = '0;
                n_pw   = n_w;
                n_ph   = n_h;
                n_pend = 1'b1;
            end else begin
                n_row = r_row + ONE_H;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_w    <= '0;
            r_h    <= '0;
            r_pw   <= '0;
            r_ph   <= '0;
            r_pend <= 1'b0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_w    <= n_w;
            r_h    <= n_h;
            r_pw   <= n_pw;
            r_ph   <= n_ph;
            r_pend <= n_pend;
        end
    end

    assign o_emit = emit;
    assign o_col  = r_col;
    assign o_ctl.column  = r_col;
    assign o_ctl.row     = res_row;
    assign o_ctl.last    = (cx_w == row_w - ONE_W) && (res_row == row_h - ONE_H);
    assign o_ctl.left_v  = (r_col != '0);
    assign o_ctl.right_v = (cx1 < row_w);
    assign o_ctl.above_v = (res_row != '0);
    assign o_ctl.below_v = (r_row != '0);

endmodule

FILE: sv/cmg_line_store.sv
`timescale 1ns / 1ps
// Centre and above line stores with registered reads and the left neighbour register.
module cmg_line_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [cmg_pkg::COL_BITS-1:0]  i_col,
    input  cmg_pkg::t_level               i_level,
    output cmg_pkg::t_level               o_centre,
    output cmg_pkg::t_level               o_right,
    output cmg_pkg::t_level               o_above,
    output cmg_pkg::t_level               o_left
);

    cmg_pkg::t_level mem_centre [cmg_pkg::MAX_WIDTH];
    cmg_pkg::t_level mem_above  [cmg_pkg::MAX_WIDTH];

    cmg_pkg::t_level              r_centre_q;
    cmg_pkg::t_level              r_right_q;
    cmg_pkg::t_level              r_above_q;
    cmg_pkg::t_level              r_left_q;
    logic                         r_wpend;
    logic [cmg_pkg::COL_BITS-1:0] r_waddr;
    logic [cmg_pkg::COL_BITS-1:0] col_next;
    logic                         fwd;

    assign col_next = i_col + cmg_pkg::COL_BITS'(1);
    // above entry still being written from the previous item
    assign fwd = r_wpend && (r_waddr == i_col);

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_centre_q        <= mem_centre[i_col];
            r_right_q         <= mem_centre[col_next];
            mem_centre[i_col] <= i_level;
            r_left_q          <= r_centre_q;
            r_waddr           <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_above_q <= fwd ? r_centre_q : mem_above[i_col];
        end
        if (r_wpend) begin
            mem_above[r_waddr] <= r_centre_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpend <= 1'b0;
        end else begin
            r_wpend <= i_accept;
        end
    end

    assign o_centre = r_centre_q;
    assign o_right  = r_right_q;
    assign o_above  = r_above_q;
    assign o_left   = r_left_q;

endmodule

FILE: sv/cmg_diff_stage.sv
`timescale 1ns / 1ps
// Window stage: largest absolute difference between centre and its four neighbours.
module cmg_diff_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_emit,
    input  cmg_pkg::t_item_ctl   i_ctl,
    input  cmg_pkg::t_level      i_level,
    input  cmg_pkg::t_level      i_centre,
    input  cmg_pkg::t_level      i_right,
    input  cmg_pkg::t_level      i_above,
    input  cmg_pkg::t_level      i_left,
    input  logic                 i_next_free,
    output logic                 o_free,
    output logic                 o_valid,
    output cmg_pkg::t_diff_item  o_item
);

    logic                r_a_valid;
    cmg_pkg::t_item_ctl  r_a_ctl;
    cmg_pkg::t_level     r_a_level;
    logic                r_b_valid;
    cmg_pkg::t_diff_item r_b_item, n_b_item;
    logic                b_free;

    cmg_pkg::t_level n_left, n_right, n_above, n_below;
    cmg_pkg::t_level d_left, d_right, d_above, d_below, d_lr, d_ab;

    function automatic cmg_pkg::t_level abs_diff(cmg_pkg::t_level a, cmg_pkg::t_level b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign b_free = !r_b_valid || i_next_free;
    assign o_free = !r_a_valid || b_free;

    always_comb begin
        // drop neighbours outside the frame
        n_left  = r_a_ctl.left_v  ? i_left    : '0;
        n_right = r_a_ctl.right_v ? i_right   : '0;
        n_above = r_a_ctl.above_v ? i_above   : '0;
        n_below = r_a_ctl.below_v ? r_a_level : '0;
        d_left  = abs_diff(i_centre, n_left);
        d_right = abs_diff(i_centre, n_right);
        d_above = abs_diff(i_centre, n_above);
        d_below = abs_diff(i_centre, n_below);
        d_lr    = (d_right > d_left) ? d_right : d_left;
        d_ab    = (d_below > d_above) ? d_below : d_above;
        n_b_item.diff   = (d_ab > d_lr) ? d_ab : d_lr;
        n_b_item.column = r_a_ctl.column;
        n_b_item.row    = r_a_ctl.row;
        n_b_item.last   = r_a_ctl.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_a_valid <= i_emit;
            end else if (b_free) begin
                r_a_valid <= 1'b0;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_ctl   <= i_ctl;
            r_a_level <= i_level;
        end
        if (b_free) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

FILE: sv/cmg_scale_out.sv
`timescale 1ns / 1ps
// Output stage: gain scaling, rounding, saturation and the result register.
module cmg_scale_out (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  cmg_pkg::t_diff_item            i_item,
    input  logic [cmg_pkg::GAIN_BITS-1:0]  i_gain,
    input  logic                           i_out_ready,
    output logic                           o_free,
    output logic                           o_out_valid,
    output logic [cmg_pkg::OUT_BITS-1:0]   o_edge_level,
    output logic [cmg_pkg::COL_BITS-1:0]   o_column,
    output logic [cmg_pkg::ROW_BITS-1:0]   o_row_index,
    output logic                           o_frame_last
);

    localparam int GD_BITS  = cmg_pkg::GAIN_BITS + cmg_pkg::FRAC_BITS;
    localparam int SC_BITS  = GD_BITS + 9;
    localparam int SH_BITS  = SC_BITS - cmg_pkg::FRAC_BITS;
    localparam logic [SC_BITS-1:0] ROUND_HALF = SC_BITS'(1) << (cmg_pkg::FRAC_BITS - 1);
    localparam logic [SH_BITS-1:0] SAT_MAX = SH_BITS'((1 << cmg_pkg::OUT_BITS) - 1);

    logic [GD_BITS-1:0]          gd;
    logic [SC_BITS-1:0]          scaled;
    logic [SH_BITS-1:0]          shifted;
    logic [cmg_pkg::OUT_BITS-1:0] n_level;

    logic                         r_valid;
    logic [cmg_pkg::OUT_BITS-1:0] r_level;
    logic [cmg_pkg::COL_BITS-1:0] r_column;
    logic [cmg_pkg::ROW_BITS-1:0] r_row;
    logic                         r_last;

    assign o_free = !r_valid || i_out_ready;

    always_comb begin
        gd = GD_BITS'(i_gain) * GD_BITS'(i_item.diff);
        // times 255 as a shift and subtract, then round half up
        scaled  = ({1'b0, gd, 8'b0} - {9'b0, gd}) + ROUND_HALF;
        shifted = scaled[SC_BITS-1:cmg_pkg::FRAC_BITS];
        n_level = (shifted > SAT_MAX) ? SAT_MAX[cmg_pkg::OUT_BITS-1:0]
                                      : shifted[cmg_pkg::OUT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_level  <= n_level;
            r_column <= i_item.column;
            r_row    <= i_item.row;
            r_last   <= i_item.last;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_edge_level = r_level;
    assign o_column     = r_column;
    assign o_row_index  = r_row;
    assign o_frame_last = r_last;

endmodule

FILE: sv/cross_max_gradient_edge_map_core.sv
`timescale 1ns / 1ps
// Top level of the four-neighbour maximum-difference edge map core.
//
// Takes one 8-bit pixel per clock in raster order and gives one edge result
// per clock when out_ready is high. Each pixel is mapped through a cubic S-curve
// table; the result for pixel (x, y) is the largest absolute level difference
// to its left, right, upper and lower neighbours (zero outside the frame), times
// edge_gain, rounded and saturated to 8 bits. Two single-port-write line stores
// of 2048 entries hold the rows above and at the centre, so the result for
// (x, y) passes the stage A, stage B and output registers after pixel (x, y+1)
// is accepted; the last row of a frame is flushed by the first row of the next
// frame. frame_width and frame_height are sampled at the first pixel of each
// frame; edge_gain is used as written. The line stores need no clearing after
// reset. Write the configuration registers only while the core is idle.
module cross_max_gradient_edge_map_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [cmg_pkg::PIX_BITS-1:0]        i_pixel_level,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [cmg_pkg::OUT_BITS-1:0]        o_edge_level,
    output logic [cmg_pkg::COL_BITS-1:0]        o_column,
    output logic [cmg_pkg::ROW_BITS-1:0]        o_row_index,
    output logic                                o_frame_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cmg_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [cmg_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    logic [cmg_pkg::WIDTH_BITS-1:0] r_frame_width;
    logic [cmg_pkg::ROW_BITS-1:0]   r_frame_height;
    logic [cmg_pkg::GAIN_BITS-1:0]  r_edge_gain;

    logic                         accept;
    logic                         emit;
    logic [cmg_pkg::COL_BITS-1:0] col;
    cmg_pkg::t_item_ctl           ctl;
    cmg_pkg::t_level              level;
    cmg_pkg::t_level              centre, right, above, left;
    logic                         a_free;
    logic                         b_valid;
    cmg_pkg::t_diff_item          b_item;
    logic                         c_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= cmg_pkg::WIDTH_RESET;
            r_frame_height <= cmg_pkg::HEIGHT_RESET;
            r_edge_gain    <= cmg_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cmg_pkg::CFG_FRAME_WIDTH:
                    r_frame_width <= i_cfg_data[cmg_pkg::WIDTH_BITS-1:0];
                cmg_pkg::CFG_FRAME_HEIGHT:
                    r_frame_height <= i_cfg_data[cmg_pkg::ROW_BITS-1:0];
                cmg_pkg::CFG_EDGE_GAIN:
                    r_edge_gain <= i_cfg_data[cmg_pkg::GAIN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = a_free;
    assign accept     = i_in_valid && a_free;
    assign level      = cmg_pkg::LEVEL_LUT[i_pixel_level];

    cmg_frame_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_emit         (emit),
        .o_col          (col),
        .o_ctl          (ctl)
    );

    cmg_line_store u_lines (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_col    (col),
        .i_level  (level),
        .o_centre (centre),
        .o_right  (right),
        .o_above  (above),
        .o_left   (left)
    );

    cmg_diff_stage u_diff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_emit      (emit),
        .i_ctl       (ctl),
        .i_level     (level),
        .i_centre    (centre),
        .i_right     (right),
        .i_above     (above),
        .i_left      (left),
        .i_next_free (c_free),
        .o_free      (a_free),
        .o_valid     (b_valid),
        .o_item      (b_item)
    );

    cmg_scale_out u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (b_valid),
        .i_item       (b_item),
        .i_gain       (r_edge_gain),
        .i_out_ready  (i_out_ready),
        .o_free       (c_free),
        .o_out_valid  (o_out_valid),
        .o_edge_level (o_edge_level),
        .o_column     (o_column),
        .o_row_index  (o_row_index),
        .o_frame_last (o_frame_last)
    );

endmodule
